FILE: rtl/core/olsm_pkg.sv
// Shared types, codes and permutation tables for the ordering move unit.
package olsm_pkg;

  localparam int unsigned NODE_FIELD_W = 12;
  localparam int unsigned PLACE_W      = 12;
  localparam int unsigned WEIGHT_W     = 32;
  localparam int unsigned SCORE_W      = 48;
  localparam int unsigned MOVE_NODES   = 4;
  localparam int unsigned NUM_PERMS    = 24;
  localparam int unsigned PERM_W       = 5;
  localparam int unsigned DEF_MAX_NODES = 4096;
  localparam int unsigned DEF_MAX_EDGES = 65536;

  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  typedef enum logic [2:0] {
    KIND_LOAD  = 3'd0,
    KIND_SET   = 3'd1,
    KIND_SCORE = 3'd2,
    KIND_MOVE  = 3'd3,
    KIND_READ  = 3'd4
  } olsm_kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_DIST = 2'd2
  } olsm_status_e;

  typedef struct packed {
    logic [2:0]              kind;
    logic [NODE_FIELD_W-1:0] node_a;
    logic [NODE_FIELD_W-1:0] node_b;
    logic [NODE_FIELD_W-1:0] node_c;
    logic [NODE_FIELD_W-1:0] node_d;
    logic [PLACE_W-1:0]      place;
    logic [WEIGHT_W-1:0]     edge_weight;
  } olsm_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               improved;
    logic [PERM_W-1:0]  perm_index;
    logic [SCORE_W-1:0] total_score;
    logic [PLACE_W-1:0] place_out;
  } olsm_out_t;

  // Per-edge lookup that every lane sees in the same cycle
  typedef struct packed {
    logic                  valid;
    logic                  clear;
    logic [MOVE_NODES-1:0] hit_u;
    logic [MOVE_NODES-1:0] hit_v;
    logic [PLACE_W-1:0]    place_u;
    logic [PLACE_W-1:0]    place_v;
    logic [WEIGHT_W-1:0]   weight;
  } olsm_edge_beat_t;

  // Recursive swap order: slot i of permutation p names the move node that
  // receives original position i.
  localparam logic [1:0] PERM [NUM_PERMS][MOVE_NODES] = '{
    '{2'd0,2'd1,2'd2,2'd3}, '{2'd0,2'd1,2'd3,2'd2}, '{2'd0,2'd2,2'd1,2'd3},
    '{2'd0,2'd2,2'd3,2'd1}, '{2'd0,2'd3,2'd2,2'd1}, '{2'd0,2'd3,2'd1,2'd2},
    '{2'd1,2'd0,2'd2,2'd3}, '{2'd1,2'd0,2'd3,2'd2}, '{2'd1,2'd2,2'd0,2'd3},
    '{2'd1,2'd2,2'd3,2'd0}, '{2'd1,2'd3,2'd2,2'd0}, '{2'd1,2'd3,2'd0,2'd2},
    '{2'd2,2'd1,2'd0,2'd3}, '{2'd2,2'd1,2'd3,2'd0}, '{2'd2,2'd0,2'd1,2'd3},
    '{2'd2,2'd0,2'd3,2'd1}, '{2'd2,2'd3,2'd0,2'd1}, '{2'd2,2'd3,2'd1,2'd0},
    '{2'd3,2'd1,2'd2,2'd0}, '{2'd3,2'd1,2'd0,2'd2}, '{2'd3,2'd2,2'd1,2'd0},
    '{2'd3,2'd2,2'd0,2'd1}, '{2'd3,2'd0,2'd2,2'd1}, '{2'd3,2'd0,2'd1,2'd2}
  };

  // Which original position move node j receives under permutation p
  function automatic logic [1:0] perm_inv(input int unsigned p, input int unsigned j);
    logic [1:0] r;
    r = 2'd0;
    for (int i = 0; i < MOVE_NODES; i++) begin
      if (PERM[p][i] == j[1:0]) r = i[1:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/olsm_lane.sv
// One permutation lane: accumulates the signed score change over the edge scan.
module olsm_lane #(
  parameter int unsigned LANE    = 0,
  parameter int unsigned DELTA_W = 53
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  olsm_pkg::olsm_edge_beat_t                     beat_i,
  input  logic [olsm_pkg::MOVE_NODES-1:0][olsm_pkg::PLACE_W-1:0] orig_i,
  output logic [DELTA_W-1:0]                            delta_o
);
  import olsm_pkg::*;

  logic [DELTA_W-1:0] acc_q, acc_d;
  logic [PLACE_W-1:0] new_u, new_v;
  logic               old_fwd, new_fwd;

  // Moved positions of both endpoints under this lane's permutation
  always_comb begin
    new_u = beat_i.place_u;
    new_v = beat_i.place_v;
    for (int j = 0; j < MOVE_NODES; j++) begin
      if (beat_i.hit_u[j]) new_u = orig_i[perm_inv(LANE, j)];
      if (beat_i.hit_v[j]) new_v = orig_i[perm_inv(LANE, j)];
    end
    old_fwd = beat_i.place_u < beat_i.place_v;
    new_fwd = new_u < new_v;
    acc_d = acc_q;
    if (beat_i.clear) begin
      acc_d = '0;
    end else if (beat_i.valid) begin
      if (new_fwd && !old_fwd) acc_d = acc_q + DELTA_W'(beat_i.weight);
      else if (old_fwd && !new_fwd) acc_d = acc_q - DELTA_W'(beat_i.weight);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign delta_o = acc_q;

endmodule

FILE: rtl/core/olsm_merge.sv
// Picks the first lane in swap order with a strictly positive gain.
module olsm_merge #(
  parameter int unsigned DELTA_W = 53
) (
  input  logic [olsm_pkg::NUM_PERMS-1:0][DELTA_W-1:0] delta_i,
  output logic                                        found_o,
  output logic [olsm_pkg::PERM_W-1:0]                 index_o,
  output logic [DELTA_W-1:0]                          gain_o
);
  import olsm_pkg::*;

  // Scan from the last lane down so the lowest index wins
  always_comb begin
    found_o = 1'b0;
    index_o = '0;
    gain_o  = '0;
    for (int p = NUM_PERMS - 1; p >= 0; p--) begin
      if (!delta_i[p][DELTA_W-1] && (delta_i[p] != '0)) begin
        found_o = 1'b1;
        index_o = PERM_W'(p);
        gain_o  = delta_i[p];
      end
    end
  end

endmodule

FILE: rtl/core/ordering_local_search_move_unit.sv
// Top level of the ordering local-search move unit.
// Load, set and read items pass through the execute and done states, and
// their result beat is registered in the done state.
// Score items and moves with four distinct nodes scan every stored edge once
// through the edge memory at one edge per cycle; a move that improves then
// writes the four new positions through the position memory's single write
// port. A stalled result holds the unit and its input until the result beat
// is taken. A move evaluates all 24 permutations at once in 24 lanes during
// that single scan.
// Positions and edges are undefined until written.
module ordering_local_search_move_unit #(
  parameter int unsigned MAX_NODES = olsm_pkg::DEF_MAX_NODES,
  parameter int unsigned MAX_EDGES = olsm_pkg::DEF_MAX_EDGES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  olsm_pkg::olsm_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output olsm_pkg::olsm_out_t out_data_o
);
  import olsm_pkg::*;

  localparam int unsigned NW      = $clog2(MAX_NODES);
  localparam int unsigned TW      = $clog2(MAX_EDGES + 1);
  localparam int unsigned EAW     = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned DELTA_W = TW + WEIGHT_W + 1;
  localparam int unsigned SUM_W   = ((DELTA_W > SCORE_W) ? DELTA_W : SCORE_W) + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_ORIG0, S_ORIG1, S_SCAN, S_PICK, S_APPLY, S_DONE
  } olsm_state_e;

  typedef struct packed {
    logic [NW-1:0]       src;
    logic [NW-1:0]       dst;
    logic [WEIGHT_W-1:0] wt;
  } edge_t;

  // Node number reduced modulo the node count
  function automatic logic [NW-1:0] wrap(input logic [NODE_FIELD_W-1:0] v);
    logic [NODE_FIELD_W:0] r;
    r = {1'b0, v};
    for (int k = NODE_FIELD_W - 1; k >= 0; k--) begin
      if ((MAX_NODES << k) < (1 << NODE_FIELD_W)) begin
        if (r >= (NODE_FIELD_W+1)'(MAX_NODES << k)) r = r - (NODE_FIELD_W+1)'(MAX_NODES << k);
      end
    end
    return NW'(r);
  endfunction

  olsm_state_e state_q, state_d;
  olsm_in_t    item_q;
  logic [MOVE_NODES-1:0][NW-1:0]      sel_q;
  logic [MOVE_NODES-1:0][PLACE_W-1:0] orig_q;
  logic [TW-1:0]      edge_total_q, scan_q;
  logic [SCORE_W-1:0] score_q, sum_q;
  logic [1:0]         status_q;
  logic               improved_q;
  logic [PERM_W-1:0]  pidx_q;
  logic [1:0]         apply_q;
  olsm_out_t          out_q;
  logic               out_valid_q;

  // Memories
  edge_t              edge_mem [MAX_EDGES];
  logic [PLACE_W-1:0] place_mem [MAX_NODES];
  edge_t              e_q;
  logic [PLACE_W-1:0] pa_q, pb_q;
  logic               e_we, p_we, ra_en;
  logic [NW-1:0]      p_waddr, ra_addr, rb_addr;
  logic [PLACE_W-1:0] p_wdata;

  // Scan pipeline
  logic v1_q, v2_q;
  logic [NW-1:0]       src2_q, dst2_q;
  logic [WEIGHT_W-1:0] wt2_q;
  logic                issue;
  logic                is_move;
  logic                distinct;
  logic [SUM_W-1:0]    gain_sum, part_sum;

  olsm_edge_beat_t beat;
  logic [NUM_PERMS-1:0][DELTA_W-1:0] delta;
  logic               found;
  logic [PERM_W-1:0]  found_idx;
  logic [DELTA_W-1:0] found_gain;

  assign is_move = (item_q.kind == KIND_MOVE);
  assign issue   = (state_q == S_SCAN) && (scan_q < edge_total_q);

  // Distinctness of the move nodes after reduction
  always_comb begin
    distinct = 1'b1;
    for (int i = 0; i < MOVE_NODES; i++) begin
      for (int j = i + 1; j < MOVE_NODES; j++) begin
        if (sel_q[i] == sel_q[j]) distinct = 1'b0;
      end
    end
  end

  // Beat shared by all lanes
  always_comb begin
    beat.valid   = v2_q;
    beat.clear   = (state_q == S_ORIG1);
    beat.place_u = pa_q;
    beat.place_v = pb_q;
    beat.weight  = wt2_q;
    for (int j = 0; j < MOVE_NODES; j++) begin
      beat.hit_u[j] = (src2_q == sel_q[j]);
      beat.hit_v[j] = (dst2_q == sel_q[j]);
    end
  end

  for (genvar p = 0; p < NUM_PERMS; p++) begin : g_lane
    olsm_lane #(.LANE(p), .DELTA_W(DELTA_W)) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .beat_i  (beat),
      .orig_i  (orig_q),
      .delta_o (delta[p])
    );
  end

  olsm_merge #(.DELTA_W(DELTA_W)) u_merge (
    .delta_i (delta),
    .found_o (found),
    .index_o (found_idx),
    .gain_o  (found_gain)
  );

  assign gain_sum = SUM_W'(score_q) + SUM_W'(found_gain);
  assign part_sum = SUM_W'(sum_q) + SUM_W'(wt2_q);

  // Control: next state, memory ports
  always_comb begin
    state_d = state_q;
    e_we    = 1'b0;
    p_we    = 1'b0;
    p_waddr = sel_q[0];
    p_wdata = item_q.place;
    ra_en   = 1'b0;
    ra_addr = e_q.src;
    rb_addr = e_q.dst;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_EXEC;
      S_EXEC: begin
        state_d = S_DONE;
        case (item_q.kind)
          KIND_LOAD: e_we = (edge_total_q != TW'(MAX_EDGES));
          KIND_SET:  p_we = 1'b1;
          KIND_READ: begin
            ra_en   = 1'b1;
            ra_addr = sel_q[0];
          end
          KIND_SCORE: state_d = S_SCAN;
          KIND_MOVE: begin
            if (distinct) begin
              ra_en   = 1'b1;
              ra_addr = sel_q[0];
              rb_addr = sel_q[1];
              state_d = S_ORIG0;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_ORIG0: begin
        ra_en   = 1'b1;
        ra_addr = sel_q[2];
        rb_addr = sel_q[3];
        state_d = S_ORIG1;
      end
      S_ORIG1: state_d = S_SCAN;
      S_SCAN: begin
        ra_en = v1_q;
        if (!issue && !v1_q && !v2_q) state_d = is_move ? S_PICK : S_DONE;
      end
      S_PICK:  state_d = found ? S_APPLY : S_DONE;
      S_APPLY: begin
        p_we    = 1'b1;
        p_waddr = sel_q[PERM[pidx_q][apply_q]];
        p_wdata = orig_q[apply_q];
        if (apply_q == 2'd3) state_d = S_DONE;
      end
      S_DONE:  if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Memory arrays: edge store and position table
  always_ff @(posedge clk_i) begin
    if (e_we) edge_mem[edge_total_q[EAW-1:0]] <= '{src: sel_q[0], dst: sel_q[1],
                                                   wt: item_q.edge_weight};
    if (issue) e_q <= edge_mem[scan_q[EAW-1:0]];
    if (p_we) place_mem[p_waddr] <= p_wdata;
    if (ra_en) begin
      pa_q <= place_mem[ra_addr];
      pb_q <= place_mem[rb_addr];
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      item_q   <= in_data_i;
      sel_q[0] <= wrap(in_data_i.node_a);
      sel_q[1] <= wrap(in_data_i.node_b);
      sel_q[2] <= wrap(in_data_i.node_c);
      sel_q[3] <= wrap(in_data_i.node_d);
    end
    if (state_q == S_ORIG0) orig_q[1:0] <= {pb_q, pa_q};
    if (state_q == S_ORIG1) orig_q[3:2] <= {pb_q, pa_q};
    src2_q <= e_q.src;
    dst2_q <= e_q.dst;
    wt2_q  <= e_q.wt;
  end

  // Control and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_total_q <= '0;
      score_q      <= '0;
      sum_q        <= '0;
      scan_q       <= '0;
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      status_q     <= ST_OK;
      improved_q   <= 1'b0;
      pidx_q       <= '0;
      apply_q      <= '0;
      out_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      if (issue) scan_q <= scan_q + TW'(1);
      if (state_q == S_IDLE) begin
        scan_q     <= '0;
        sum_q      <= '0;
        status_q   <= ST_OK;
        improved_q <= 1'b0;
        pidx_q     <= '0;
        apply_q    <= '0;
      end
      if (state_q == S_EXEC) begin
        if (item_q.kind == KIND_LOAD) begin
          if (edge_total_q == TW'(MAX_EDGES)) status_q <= ST_FULL;
          else edge_total_q <= edge_total_q + TW'(1);
        end
        if (is_move && !distinct) status_q <= ST_NOT_DIST;
      end
      // Saturating forward-edge sum for score items
      if (state_q == S_SCAN && v2_q && pa_q < pb_q) begin
        sum_q <= (part_sum > SUM_W'(SCORE_MAX)) ? SCORE_MAX : part_sum[SCORE_W-1:0];
      end
      if (state_q == S_SCAN && state_d == S_DONE) score_q <= sum_q;
      if (state_q == S_PICK && found) begin
        improved_q <= 1'b1;
        pidx_q     <= found_idx;
        score_q    <= (gain_sum > SUM_W'(SCORE_MAX)) ? SCORE_MAX : gain_sum[SCORE_W-1:0];
      end
      if (state_q == S_APPLY) apply_q <= apply_q + 2'd1;
      // Output register
      if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
        out_valid_q       <= 1'b1;
        out_q.status      <= status_q;
        out_q.improved    <= improved_q;
        out_q.perm_index  <= pidx_q;
        out_q.total_score <= score_q;
        out_q.place_out   <= (item_q.kind == KIND_READ) ? pa_q : '0;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: tb/ordering_local_search_move_unit_test.sv
// Self-checking testbench for the ordering local-search move unit.
`timescale 1ns / 1ps

module ordering_local_search_move_unit_test;
  import olsm_pkg::*;

  localparam int unsigned NODES = DEF_MAX_NODES;

  // Scoreboard: keeps its own copy of positions, edges and score
  class move_scoreboard;
    logic [PLACE_W-1:0]  place_tab [NODES];
    logic [11:0]         src_q [$];
    logic [11:0]         dst_q [$];
    logic [WEIGHT_W-1:0] wt_q [$];
    logic [SCORE_W-1:0]  score;
    olsm_out_t           pending [$];
    int                  mismatches;

    function new();
      score = '0;
      mismatches = 0;
      foreach (place_tab[i]) place_tab[i] = '0;
    endfunction

    function logic [SCORE_W-1:0] sat_sum(logic [SCORE_W-1:0] a, logic [63:0] b);
      logic [63:0] s;
      s = {16'd0, a} + b;
      return (s > {16'd0, SCORE_MAX}) ? SCORE_MAX : s[SCORE_W-1:0];
    endfunction

    // Position of node x with the move nodes placed per the trial arrangement
    function logic [PLACE_W-1:0] trial_place(logic [11:0] x, logic [11:0] sel[4],
                                             logic [PLACE_W-1:0] np[4]);
      for (int i = 0; i < 4; i++) if (sel[i] == x) return np[i];
      return place_tab[x];
    endfunction

    // Note an accepted input beat and queue the answer it should produce
    function void note_input(olsm_in_t it);
      olsm_out_t r;
      logic [11:0] sel[4];
      logic [11:0] nn[4];
      logic [PLACE_W-1:0] orig[4];
      logic [63:0] s;
      longint delta;
      bit distinct, oc, nc;
      r = '0;
      case (it.kind)
        KIND_LOAD: begin
          if (src_q.size() >= DEF_MAX_EDGES) r.status = ST_FULL;
          else begin
            src_q.push_back(it.node_a);
            dst_q.push_back(it.node_b);
            wt_q.push_back(it.edge_weight);
          end
        end
        KIND_SET: place_tab[it.node_a] = it.place;
        KIND_SCORE: begin
          s = '0;
          foreach (src_q[e])
            if (place_tab[src_q[e]] < place_tab[dst_q[e]]) s = sat_sum(s, wt_q[e]);
          score = s[SCORE_W-1:0];
        end
        KIND_MOVE: begin
          sel = '{it.node_a, it.node_b, it.node_c, it.node_d};
          distinct = 1'b1;
          for (int i = 0; i < 4; i++)
            for (int j = i + 1; j < 4; j++) if (sel[i] == sel[j]) distinct = 1'b0;
          if (!distinct) r.status = ST_NOT_DIST;
          else begin
            for (int i = 0; i < 4; i++) orig[i] = place_tab[sel[i]];
            for (int p = 0; p < NUM_PERMS; p++) begin
              for (int i = 0; i < 4; i++) nn[i] = sel[PERM[p][i]];
              delta = 0;
              foreach (src_q[e]) begin
                oc = place_tab[src_q[e]] < place_tab[dst_q[e]];
                nc = trial_place(src_q[e], nn, orig) < trial_place(dst_q[e], nn, orig);
                if (nc && !oc) delta += wt_q[e];
                else if (oc && !nc) delta -= wt_q[e];
              end
              if (delta > 0) begin
                for (int i = 0; i < 4; i++) place_tab[nn[i]] = orig[i];
                score = sat_sum(score, delta);
                r.improved = 1'b1;
                r.perm_index = PERM_W'(p);
                break;
              end
            end
          end
        end
        KIND_READ: r.place_out = place_tab[it.node_a];
        default: ;
      endcase
      r.total_score = score;
      pending.push_back(r);
    endfunction

    // Compare an accepted output beat with the oldest expectation
    function void check_result(olsm_out_t got);
      olsm_out_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got.status !== exp_r.status || got.improved !== exp_r.improved ||
          got.perm_index !== exp_r.perm_index ||
          got.total_score !== exp_r.total_score || got.place_out !== exp_r.place_out) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp st=%0d imp=%0d p=%0d sc=%h pl=%0d got st=%0d imp=%0d p=%0d sc=%h pl=%0d",
                   exp_r.status, exp_r.improved, exp_r.perm_index, exp_r.total_score,
                   exp_r.place_out, got.status, got.improved, got.perm_index,
                   got.total_score, got.place_out);
      end
    endfunction
  endclass

  logic      clk_i = 0;
  logic      rst_ni = 0;
  logic      in_valid_i = 0;
  logic      in_stall_o;
  olsm_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1;
  olsm_out_t out_data_o;

  move_scoreboard board;
  logic [11:0] used_nodes [$];
  bit quiet;      // no idling in the last part
  int hold_off;   // long receiver stall request

  ordering_local_search_move_unit uut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // Send one beat, with random idle bursts ahead of it
  task automatic send(olsm_in_t it);
    int gap;
    if (!quiet && $urandom_range(3) == 0) begin
      gap = $urandom_range(12, 1);
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    board.note_input(it);
    if (it.kind == KIND_SET) used_nodes.push_back(it.node_a);
  endtask

  function automatic olsm_in_t mk(olsm_kind_e k, logic [11:0] a, logic [11:0] b,
                                  logic [11:0] c, logic [11:0] d, logic [11:0] pl,
                                  logic [31:0] w);
    olsm_in_t it;
    it.kind = k; it.node_a = a; it.node_b = b; it.node_c = c; it.node_d = d;
    it.place = pl; it.edge_weight = w;
    return it;
  endfunction

  // Pick a node that already has a position
  function automatic logic [11:0] known_node();
    return used_nodes[$urandom_range(used_nodes.size() - 1)];
  endfunction

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_off > 0) begin
        out_stall_i <= 1;
        repeat (hold_off) @(posedge clk_i);
        hold_off = 0;
      end else if (!quiet && $urandom_range(3) == 0) begin
        n = $urandom_range(12, 1);
        out_stall_i <= 1;
        repeat (n) @(posedge clk_i);
      end else begin
        out_stall_i <= 0;
        @(posedge clk_i);
      end
    end
  end

  // Output monitor
  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(out_data_o);

  initial begin
    #50ms;
    $display("ordering_local_search_move_unit_test: FAIL");
    $finish;
  end

  initial begin
    logic [11:0] a, b, c, d;
    int wait_cnt;
    int r;
    board = new();
    quiet = 0;
    hold_off = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: positions, edges with extreme weights, self loop, every kind
    send(mk(KIND_SET, 12'd0, 0, 0, 0, 12'd4095, 0));
    send(mk(KIND_SET, 12'd4095, 0, 0, 0, 12'd0, 0));
    send(mk(KIND_SET, 12'd1, 0, 0, 0, 12'd1, 0));
    send(mk(KIND_SET, 12'd2, 0, 0, 0, 12'd2, 0));
    send(mk(KIND_READ, 12'd0, 0, 0, 0, 0, 0));
    send(mk(KIND_READ, 12'd4095, 0, 0, 0, 0, 0));
    send(mk(KIND_SCORE, 0, 0, 0, 0, 0, 0));
    send(mk(KIND_LOAD, 12'd0, 12'd4095, 0, 0, 0, 32'hFFFF_FFFF));
    send(mk(KIND_LOAD, 12'd1, 12'd1, 0, 0, 0, 32'h0001_0000));
    send(mk(KIND_LOAD, 12'd2, 12'd1, 0, 0, 0, 32'd0));
    // Move before a new score item adds to the stale score
    send(mk(KIND_MOVE, 12'd0, 12'd4095, 12'd1, 12'd2, 0, 0));
    send(mk(KIND_SCORE, 0, 0, 0, 0, 0, 0));
    send(mk(KIND_MOVE, 12'd0, 12'd0, 12'd1, 12'd2, 0, 0));
    send(mk(KIND_MOVE, 12'd0, 12'd1, 12'd2, 12'd2, 0, 0));
    send(mk(KIND_MOVE, 12'd0, 12'd4095, 12'd1, 12'd2, 0, 0));
    send(mk(olsm_kind_e'(3'd5), 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, '1));
    send(mk(olsm_kind_e'(3'd7), 0, 0, 0, 0, 0, 0));
    // Score with four more max-weight edges from node 4095 to node 0
    for (int i = 0; i < 4; i++) send(mk(KIND_LOAD, 12'd4095, 12'd0, 0, 0, 0, '1));
    send(mk(KIND_SET, 12'd4095, 0, 0, 0, 12'd3, 0));
    send(mk(KIND_SCORE, 0, 0, 0, 0, 0, 0));
    send(mk(KIND_READ, 12'd2, 0, 0, 0, 0, 0));

    // Pressure: hold the output off while offering more items
    hold_off = 300;
    for (int i = 0; i < 8; i++) send(mk(KIND_READ, known_node(), 0, 0, 0, 0, 0));

    // Give every node of the edge pool a position before random edges
    for (int i = 3; i < 16; i++)
      send(mk(KIND_SET, 12'(i), 0, 0, 0, 12'($urandom), 0));

    // Random: mostly well-formed on a small node pool
    for (int n = 0; n < 60; n++) begin
      if (n == 48) quiet = 1;
      r = $urandom_range(99);
      a = 12'($urandom_range(4095));
      if (r < 20) begin
        send(mk(KIND_SET, (r < 15) ? 12'($urandom_range(15)) : a, 0, 0, 0,
                12'($urandom), 0));
      end else if (r < 45) begin
        send(mk(KIND_LOAD, 12'($urandom_range(15)), 12'($urandom_range(15)),
                12'($urandom), 12'($urandom), 12'($urandom),
                ($urandom_range(9) == 0) ? '1 : $urandom));
      end else if (r < 55) begin
        send(mk(KIND_SCORE, a, 12'($urandom), 12'($urandom), 12'($urandom),
                12'($urandom), $urandom));
      end else if (r < 85 && used_nodes.size() >= 4) begin
        do begin
          a = known_node(); b = known_node(); c = known_node(); d = known_node();
        end while ($urandom_range(7) != 0 &&
                   (a == b || a == c || a == d || b == c || b == d || c == d));
        send(mk(KIND_MOVE, a, b, c, d, 12'($urandom), $urandom));
      end else if (r < 95 && used_nodes.size() > 0) begin
        send(mk(KIND_READ, known_node(), 12'($urandom), 12'($urandom), 12'($urandom),
                12'($urandom), $urandom));
      end else begin
        send(mk(olsm_kind_e'(3'($urandom_range(7, 5))), a, 12'($urandom), 12'($urandom),
                12'($urandom), 12'($urandom), $urandom));
      end
    end
    in_valid_i <= 0;

    // Drain
    wait_cnt = 0;
    while (board.pending.size() != 0 && wait_cnt < 200000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (50) @(posedge clk_i);
    if (board.pending.size() == 0 && board.mismatches == 0)
      $display("ordering_local_search_move_unit_test: PASS");
    else
      $display("ordering_local_search_move_unit_test: FAIL");
    $finish;
  end

endmodule
